### src/assert_macros.svh
// Assertion macros for the RTL files (included by i2cee_engine).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// Types and constants of the EEPROM I2C master.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    typedef enum logic [3:0] {
        S_IDLE    = 4'd0,
        S_START   = 4'd1,
        S_TX_DEV  = 4'd2,
        S_AK_DEV  = 4'd3,
        S_TX_WORD = 4'd4,
        S_AK_WORD = 4'd5,
        S_TX_DATA = 4'd6,
        S_AK_DATA = 4'd7,
        S_RESTART = 4'd8,
        S_TX_RDEV = 4'd9,
        S_AK_RDEV = 4'd10,
        S_RX      = 4'd11,
        S_MACK    = 4'd12,
        S_NACK    = 4'd13,
        S_STOP    = 4'd14,
        S_WAIT    = 4'd15
    } step_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DEV_NACK  = 3'd1,
        ST_WORD_NACK = 3'd2,
        ST_DATA_NACK = 3'd3,
        ST_RADR_NACK = 3'd4
    } status_t;

    localparam logic [1:0] REG_SLAVE = 2'd0;
    localparam logic [1:0] REG_PHASE = 2'd1;
    localparam logic [1:0] REG_WAIT  = 2'd2;

    localparam logic [7:0] RST_SLAVE = 8'd160;
    localparam logic [7:0] RST_PHASE = 8'd10;
    localparam logic [7:0] RST_WAIT  = 8'd10;

    typedef struct packed {
        logic       command_valid;
        logic       operation;
        logic [7:0] word_address;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
        logic       ms_tick;
    } cmd_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic [7:0] read_data;
        logic       read_valid;
        logic       data_request;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
    } res_t;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] phase_ticks;
        logic [7:0] write_wait_ms;
    } cfg_t;

endpackage

### src/i2cee_if.sv
// ----------------------------------------------------------------------------
// i2cee_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface i2cee_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/i2c_eeprom_master.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_master
// Tick-driven I2C master for serial EEPROM page write and sequential read.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | command_valid operation word_address byte_count write_data
//          |     | sda_in ms_tick (one request per bus tick)
//  res     | out | scl sda_out sda_drive read_data read_valid data_request
//          |     | busy_res done_res status (one per request)
//
//  Each request is one tick; the engine handles one per clock while its
//  skid stage is empty, so the sustained rate is one request per cycle, set
//  by the sequencer's single next-state step. A request passes the queue,
//  then the output register. A stall on res fills the skid stage and then the
//  queue before req stalls. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module i2c_eeprom_master #(
    parameter int MAX_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    i2cee_if.sink       req,
    i2cee_if.source     res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import i2cee_pkg::*;

    cfg_t cfg_reg;
    logic q_valid, q_ready;
    cmd_t q_data;

    // the user writes these registers only while idle (not enforced here); taken at once by the engine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address <= RST_SLAVE;
            cfg_reg.phase_ticks   <= RST_PHASE;
            cfg_reg.write_wait_ms <= RST_WAIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SLAVE: cfg_reg.slave_address <= cfg_data;
                REG_PHASE: cfg_reg.phase_ticks   <= cfg_data;
                REG_WAIT:  cfg_reg.write_wait_ms <= cfg_data;
                default:   ;
            endcase
        end
    end

    // front: request queue
    i2cee_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_data   (req.data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // back: bus sequencer with output skid
    i2cee_engine #(.MAX_BYTES(MAX_BYTES)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (res.data)
    );
endmodule

### src/i2cee_queue.sv
// ----------------------------------------------------------------------------
// i2cee_queue
// Two-entry request queue between the front and the bus engine.
// ----------------------------------------------------------------------------
module i2cee_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cee_pkg::cmd_t     in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cee_pkg::cmd_t     out_data
);
    import i2cee_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end
endmodule

### src/i2cee_engine.sv
// ----------------------------------------------------------------------------
// i2cee_engine
// Bus sequencer: one tick per request, one result per tick into an output register with a skid stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cee_engine #(
    parameter int MAX_BYTES = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  i2cee_pkg::cfg_t     cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cee_pkg::cmd_t     in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cee_pkg::res_t     out_data
);
    import i2cee_pkg::*;

    localparam logic [8:0] MAX_CNT = 9'(MAX_BYTES);

    step_t      step_reg, step_next;
    logic [1:0] sub_reg, sub_next;
    logic [7:0] pc_reg, pc_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] sh_reg, sh_next;
    logic [8:0] left_reg, left_next;
    logic       ack_reg, ack_next;
    logic [7:0] wc_reg, wc_next;
    logic       rm_reg, rm_next;
    logic [7:0] wa_reg, wa_next;
    logic [2:0] st_reg, st_next;
    logic       scl_reg, scl_next, sda_reg, sda_next, drv_reg, drv_next;
    logic [7:0] rdata;
    logic       rvalid, done;
    logic       go;
    res_t       res;

    // output register plus skid entry
    logic       ov_reg, sv_reg;
    res_t       od_reg, sd_reg;

    assign in_ready  = !sv_reg;
    assign go        = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    function automatic logic is_tx(step_t s);
        return s == S_TX_DEV || s == S_TX_WORD || s == S_TX_DATA || s == S_TX_RDEV;
    endfunction

    function automatic logic is_ack(step_t s);
        return s == S_AK_DEV || s == S_AK_WORD || s == S_AK_DATA || s == S_AK_RDEV;
    endfunction

    always_comb
    begin
        logic [7:0] pt;
        logic [8:0] cnt;
        logic       do_enter;
        step_t      es;
        logic [1:0] ep;
        logic [1:0] last;
        logic [3:0] bn;
        pt = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
        step_next = step_reg; sub_next = sub_reg; pc_next = pc_reg;
        bit_next = bit_reg; sh_next = sh_reg; left_next = left_reg;
        ack_next = ack_reg; wc_next = wc_reg; rm_next = rm_reg;
        wa_next = wa_reg; st_next = st_reg;
        scl_next = scl_reg; sda_next = sda_reg; drv_next = drv_reg;
        rdata = 8'd0; rvalid = 1'b0; done = 1'b0;
        do_enter = 1'b0; es = step_reg; ep = 2'd0;
        cnt = 9'd0; bn = 4'd0;
        last = (step_reg == S_START || step_reg == S_RESTART) ? 2'd3 : 2'd2;

        if (step_reg == S_IDLE)
        begin
            if (in_data.command_valid)
            begin
                cnt = (in_data.byte_count == 8'd0) ? 9'd256 : {1'b0, in_data.byte_count};
                if (cnt > MAX_CNT)
                begin
                    cnt = MAX_CNT;
                end
                rm_next = in_data.operation;
                wa_next = in_data.word_address;
                left_next = cnt;
                st_next = ST_OK;
                do_enter = 1'b1; es = S_START;
            end
        end
        else if (step_reg == S_WAIT)
        begin
            if (in_data.ms_tick)
            begin
                wc_next = wc_reg + 8'd1;
                if (wc_next >= cfg.write_wait_ms)
                begin
                    step_next = S_IDLE; sub_next = 2'd0; pc_next = 8'd0; done = 1'b1;
                end
            end
        end
        else
        begin
            if (is_ack(step_reg) && sub_reg == 2'd1 && !in_data.sda_in)
            begin
                ack_next = 1'b1;
            end
            if (step_reg == S_RX && sub_reg == 2'd0 && pc_reg == 8'd1)
            begin
                sh_next = {sh_reg[6:0], in_data.sda_in};
            end
            if (pc_reg > 8'd1)
            begin
                pc_next = pc_reg - 8'd1;
            end
            else if (sub_reg < last)
            begin
                do_enter = 1'b1; es = step_reg; ep = sub_reg + 2'd1;
            end
            else if (step_reg == S_START)
            begin
                sh_next = cfg.slave_address; bit_next = 4'd0;
                do_enter = 1'b1; es = S_TX_DEV;
            end
            else if (step_reg == S_RESTART)
            begin
                sh_next = cfg.slave_address | 8'h01; bit_next = 4'd0;
                do_enter = 1'b1; es = S_TX_RDEV;
            end
            else if (is_tx(step_reg))
            begin
                sh_next = {sh_reg[6:0], 1'b0};
                bn = bit_reg + 4'd1;
                bit_next = bn;
                do_enter = 1'b1;
                es = (bn < 4'd8) ? step_reg : step_t'(step_reg + 4'd1);
            end
            else if (is_ack(step_reg))
            begin
                do_enter = 1'b1;
                if (!ack_next)
                begin
                    case (step_reg)
                        S_AK_DEV:  st_next = ST_DEV_NACK;
                        S_AK_WORD: st_next = ST_WORD_NACK;
                        S_AK_DATA: st_next = ST_DATA_NACK;
                        default:   st_next = ST_RADR_NACK;
                    endcase
                    es = S_STOP;
                end
                else if (step_reg == S_AK_DEV)
                begin
                    sh_next = wa_reg; bit_next = 4'd0; es = S_TX_WORD;
                end
                else if (step_reg == S_AK_WORD)
                begin
                    if (rm_reg)
                    begin
                        es = S_RESTART;
                    end
                    else
                    begin
                        sh_next = in_data.write_data; bit_next = 4'd0; es = S_TX_DATA;
                    end
                end
                else if (step_reg == S_AK_DATA)
                begin
                    if (left_reg > 9'd0)
                    begin
                        left_next = left_reg - 9'd1;
                    end
                    if (left_next > 9'd0)
                    begin
                        sh_next = in_data.write_data; bit_next = 4'd0; es = S_TX_DATA;
                    end
                    else
                    begin
                        es = S_STOP;
                    end
                end
                else
                begin
                    sh_next = 8'd0; bit_next = 4'd0; es = S_RX;
                end
            end
            else if (step_reg == S_RX)
            begin
                bn = bit_reg + 4'd1;
                bit_next = bn;
                do_enter = 1'b1;
                if (bn < 4'd8)
                begin
                    es = S_RX;
                end
                else
                begin
                    rvalid = 1'b1; rdata = sh_next; drv_next = 1'b1;
                    if (left_reg > 9'd0)
                    begin
                        left_next = left_reg - 9'd1;
                    end
                    es = (left_next > 9'd0) ? S_MACK : S_NACK;
                end
            end
            else if (step_reg == S_MACK)
            begin
                sh_next = 8'd0; bit_next = 4'd0; do_enter = 1'b1; es = S_RX;
            end
            else if (step_reg == S_NACK)
            begin
                do_enter = 1'b1; es = S_STOP;
            end
            else
            begin
                if (!rm_reg && st_reg == ST_OK && cfg.write_wait_ms != 8'd0)
                begin
                    wc_next = 8'd0; step_next = S_WAIT; sub_next = 2'd0; pc_next = 8'd0;
                end
                else
                begin
                    step_next = S_IDLE; sub_next = 2'd0; pc_next = 8'd0; done = 1'b1;
                end
            end
        end

        if (do_enter)
        begin
            step_next = es; sub_next = ep; pc_next = pt;
            if (es == S_START || es == S_RESTART)
            begin
                case (ep)
                    2'd0:    begin sda_next = 1'b1; drv_next = 1'b1; end
                    2'd1:    scl_next = 1'b1;
                    2'd2:    sda_next = 1'b0;
                    default: scl_next = 1'b0;
                endcase
            end
            else if (is_tx(es))
            begin
                case (ep)
                    2'd0:    begin sda_next = sh_next[7]; drv_next = 1'b1; end
                    2'd1:    scl_next = 1'b1;
                    default: scl_next = 1'b0;
                endcase
            end
            else if (is_ack(es))
            begin
                case (ep)
                    2'd0:    begin drv_next = 1'b0; sda_next = 1'b1; ack_next = 1'b0; end
                    2'd1:    scl_next = 1'b1;
                    default: begin scl_next = 1'b0; drv_next = 1'b1; end
                endcase
            end
            else if (es == S_RX)
            begin
                case (ep)
                    2'd0:    begin drv_next = 1'b0; scl_next = 1'b1; end
                    2'd2:    scl_next = 1'b0;
                    default: ;
                endcase
            end
            else if (es == S_MACK || es == S_NACK)
            begin
                case (ep)
                    2'd0:    begin sda_next = (es == S_NACK); drv_next = 1'b1; end
                    2'd1:    scl_next = 1'b1;
                    default: scl_next = 1'b0;
                endcase
            end
            else
            begin
                case (ep)
                    2'd0:    begin sda_next = 1'b0; drv_next = 1'b1; end
                    2'd1:    scl_next = 1'b1;
                    default: sda_next = 1'b1;
                endcase
            end
        end

        res.scl = scl_next;
        res.sda_out = sda_next;
        res.sda_drive = drv_next;
        res.read_data = rdata;
        res.read_valid = rvalid;
        res.data_request = sub_next == 2'd2 && ack_next && !rm_next &&
            (step_next == S_AK_WORD || (step_next == S_AK_DATA && left_next > 9'd1));
        res.busy_res = step_next != S_IDLE;
        res.done_res = done;
        res.status = st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE; sub_reg <= 2'd0; pc_reg <= 8'd0; bit_reg <= 4'd0;
            sh_reg <= 8'd0; left_reg <= 9'd0; ack_reg <= 1'b0; wc_reg <= 8'd0;
            rm_reg <= 1'b0; wa_reg <= 8'd0; st_reg <= 3'd0;
            scl_reg <= 1'b1; sda_reg <= 1'b1; drv_reg <= 1'b1;
            ov_reg <= 1'b0; sv_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                step_reg <= step_next; sub_reg <= sub_next; pc_reg <= pc_next;
                bit_reg <= bit_next; sh_reg <= sh_next; left_reg <= left_next;
                ack_reg <= ack_next; wc_reg <= wc_next; rm_reg <= rm_next;
                wa_reg <= wa_next; st_reg <= st_next;
                scl_reg <= scl_next; sda_reg <= sda_next; drv_reg <= drv_next;
            end
            if (!ov_reg || out_ready)
            begin
                ov_reg <= sv_reg || go;
                sv_reg <= 1'b0;
            end
            else if (go)
            begin
                sv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || out_ready)
        begin
            od_reg <= sv_reg ? sd_reg : res;
        end
        else if (go)
        begin
            sd_reg <= res;
        end
    end

    `ASSERT_IMPL(a_skid_needs_out, clk, rst_n, sv_reg, ov_reg, "skid full without output")
    `ASSERT_NEXT(a_wait_no_pins, clk, rst_n, go && step_reg == S_WAIT && step_next == S_WAIT,
        $stable(scl_reg) && $stable(drv_reg), "pins moved during write wait")
    `ASSERT_IMPL(a_bits_range, clk, rst_n, is_tx(step_reg) || step_reg == S_RX,
        bit_reg < 4'd8, "bit counter out of range")
endmodule

### test/i2c_eeprom_master_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_master_chk
// Watches the request, result and register channels of the EEPROM I2C
// master, keeps a tick-accurate model of its sequencer and compares every
// result against the model's expectation.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_chk
    import i2cee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    i2cee_if           req,
    i2cee_if           res,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fails,
    output int         pending,
    output logic       busy,
    output logic       ack_window,
    output step_t      step_now
);

    logic [7:0] slave_q, phase_q, wait_q;
    step_t      step;
    int         sub, pc, bleft;
    logic [3:0] bitc;
    logic [7:0] shreg, waitc, hwa, rdata;
    logic       ack, rmode, scl_q, sda_q, drv_q, rvalid, done;
    logic [2:0] lstat;
    res_t       expected_bus[$];

    function automatic bit is_tx(step_t s);
        return s == S_TX_DEV || s == S_TX_WORD || s == S_TX_DATA || s == S_TX_RDEV;
    endfunction

    function automatic bit is_ack(step_t s);
        return s == S_AK_DEV || s == S_AK_WORD || s == S_AK_DATA || s == S_AK_RDEV;
    endfunction

    assign busy       = step != S_IDLE;
    assign ack_window = is_ack(step) && sub == 1;
    assign step_now   = step;

    // pin levels change on the tick that enters a phase
    task automatic enter_phase(step_t s, int p);
        step = s;
        sub  = p;
        pc   = (phase_q == 0) ? 1 : phase_q;
        if (s == S_START || s == S_RESTART) begin
            if (p == 0) begin sda_q = 1; drv_q = 1; end
            else if (p == 1) scl_q = 1;
            else if (p == 2) sda_q = 0;
            else scl_q = 0;
        end
        else if (is_tx(s)) begin
            if (p == 0) begin sda_q = shreg[7]; drv_q = 1; end
            else if (p == 1) scl_q = 1;
            else scl_q = 0;
        end
        else if (is_ack(s)) begin
            if (p == 0) begin drv_q = 0; sda_q = 1; ack = 0; end
            else if (p == 1) scl_q = 1;
            else begin scl_q = 0; drv_q = 1; end
        end
        else if (s == S_RX) begin
            if (p == 0) begin drv_q = 0; scl_q = 1; end
            else if (p == 2) scl_q = 0;
        end
        else if (s == S_MACK || s == S_NACK) begin
            if (p == 0) begin sda_q = (s == S_NACK); drv_q = 1; end
            else if (p == 1) scl_q = 1;
            else scl_q = 0;
        end
        else if (s == S_STOP) begin
            if (p == 0) begin sda_q = 0; drv_q = 1; end
            else if (p == 1) scl_q = 1;
            else sda_q = 1;
        end
    endtask

    task automatic go_idle();
        step = S_IDLE;
        sub  = 0;
        pc   = 0;
        done = 1;
    endtask

    task automatic send_byte(step_t s, logic [7:0] b);
        shreg = b;
        bitc  = 0;
        enter_phase(s, 0);
    endtask

    task automatic close_phase(logic [7:0] wdata);
        step_t s;
        int    last_sub;
        s = step;
        last_sub = (s == S_START || s == S_RESTART) ? 3 : 2;
        if (sub < last_sub)
            enter_phase(s, sub + 1);
        else if (s == S_START)
            send_byte(S_TX_DEV, slave_q);
        else if (s == S_RESTART)
            send_byte(S_TX_RDEV, slave_q | 8'h01);
        else if (is_tx(s)) begin
            shreg = shreg << 1;
            bitc  = bitc + 1;
            enter_phase(bitc < 8 ? s : step_t'(s + 1), 0);
        end
        else if (is_ack(s)) begin
            if (!ack) begin
                lstat = (s == S_AK_DEV) ? ST_DEV_NACK : (s == S_AK_WORD) ? ST_WORD_NACK
                      : (s == S_AK_DATA) ? ST_DATA_NACK : ST_RADR_NACK;
                enter_phase(S_STOP, 0);
            end
            else if (s == S_AK_DEV)
                send_byte(S_TX_WORD, hwa);
            else if (s == S_AK_WORD) begin
                if (rmode) enter_phase(S_RESTART, 0);
                else send_byte(S_TX_DATA, wdata);
            end
            else if (s == S_AK_DATA) begin
                if (bleft > 0) bleft--;
                if (bleft > 0) send_byte(S_TX_DATA, wdata);
                else enter_phase(S_STOP, 0);
            end
            else begin
                shreg = 0;
                bitc  = 0;
                enter_phase(S_RX, 0);
            end
        end
        else if (s == S_RX) begin
            bitc = bitc + 1;
            if (bitc < 8)
                enter_phase(S_RX, 0);
            else begin
                rvalid = 1;
                rdata  = shreg;
                drv_q  = 1;
                if (bleft > 0) bleft--;
                enter_phase(bleft > 0 ? S_MACK : S_NACK, 0);
            end
        end
        else if (s == S_MACK) begin
            shreg = 0;
            bitc  = 0;
            enter_phase(S_RX, 0);
        end
        else if (s == S_NACK)
            enter_phase(S_STOP, 0);
        else if (s == S_STOP) begin
            // a clean write is followed by the programming wait when one is set
            if (!rmode && lstat == ST_OK && wait_q != 0) begin
                waitc = 0;
                step  = S_WAIT;
                sub   = 0;
                pc    = 0;
            end
            else
                go_idle();
        end
        else
            go_idle();
    endtask

    task automatic bus_tick(input cmd_t c, output res_t r);
        int cnt;
        rdata  = 0;
        rvalid = 0;
        done   = 0;
        if (step == S_IDLE) begin
            if (c.command_valid) begin
                cnt   = (c.byte_count == 0) ? 256 : c.byte_count;
                rmode = c.operation;
                hwa   = c.word_address;
                bleft = cnt;
                lstat = ST_OK;
                enter_phase(S_START, 0);
            end
        end
        else if (step == S_WAIT) begin
            if (c.ms_tick) begin
                waitc = waitc + 1;
                if (waitc >= wait_q) go_idle();
            end
        end
        else begin
            if (is_ack(step) && sub == 1 && !c.sda_in) ack = 1;
            if (step == S_RX && sub == 0 && pc == 1) shreg = {shreg[6:0], c.sda_in};
            if (pc > 1) pc--;
            else close_phase(c.write_data);
        end
        r.scl          = scl_q;
        r.sda_out      = sda_q;
        r.sda_drive    = drv_q;
        r.read_data    = rdata;
        r.read_valid   = rvalid;
        r.data_request = sub == 2 && ack && !rmode &&
                         (step == S_AK_WORD || (step == S_AK_DATA && bleft > 1));
        r.busy_res     = step != S_IDLE;
        r.done_res     = done;
        r.status       = lstat;
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t r, e;
        if (!rst_n) begin
            slave_q = RST_SLAVE; phase_q = RST_PHASE; wait_q = RST_WAIT;
            step = S_IDLE; sub = 0; pc = 0; bitc = 0; shreg = 0; bleft = 0;
            ack = 0; waitc = 0; rmode = 0; hwa = 0; lstat = ST_OK;
            scl_q = 1; sda_q = 1; drv_q = 1; rdata = 0; rvalid = 0; done = 0;
            expected_bus.delete();
            fails   = 0;
            pending = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SLAVE: slave_q = cfg_data;
                    REG_PHASE: phase_q = cfg_data;
                    REG_WAIT:  wait_q  = cfg_data;
                    default: ;
                endcase
            end
            if (req.valid && req.ready) begin
                bus_tick(req.data, r);
                expected_bus.push_back(r);
            end
            if (res.valid && res.ready) begin
                r = res.data;
                if (expected_bus.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end
                else begin
                    e = expected_bus.pop_front();
                    check_field("scl", e.scl, r.scl);
                    check_field("sda_out", e.sda_out, r.sda_out);
                    check_field("sda_drive", e.sda_drive, r.sda_drive);
                    check_field("read_data", e.read_data, r.read_data);
                    check_field("read_valid", e.read_valid, r.read_valid);
                    check_field("data_request", e.data_request, r.data_request);
                    check_field("busy_res", e.busy_res, r.busy_res);
                    check_field("done_res", e.done_res, r.done_res);
                    check_field("status", e.status, r.status);
                end
            end
            pending = expected_bus.size();
        end
    end

endmodule

### test/i2c_eeprom_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_master_tb
// Drives bus ticks into the EEPROM I2C master: directed writes, reads and
// every kind of missing ack, then random transactions under several register
// settings with bursty request gaps and result stalls. The checker beside
// the DUT predicts and compares; this module only stimulates and judges.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_tb;
    import i2cee_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    int         fails, pending, cycles;
    logic       busy, ack_window;
    step_t      step_now;
    bit         gaps_on, stalls_on;
    int         stall_left;

    i2cee_if #(.T(cmd_t)) req_ch (clk);
    i2cee_if #(.T(res_t)) res_ch (clk);

    i2c_eeprom_master i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2c_eeprom_master_chk i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fails      (fails),
        .pending    (pending),
        .busy       (busy),
        .ack_window (ack_window),
        .step_now   (step_now)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: ready drops in random bursts while stalls are enabled
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(15) == 0) begin
            stall_left = $urandom_range(17, 1) - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // One bus tick. While the model sits in the SCL-high half of an ack the
    // EEPROM answer is forced: low (ack) unless this ack is the one chosen to
    // fail or a rare random nack hits. Noise ticks leave SDA fully random.
    function automatic cmd_t make_tick(bit cv, bit op, logic [7:0] wa, logic [7:0] bc,
                                       step_t nack_at, bit noise);
        cmd_t c;
        c.command_valid = cv;
        c.operation     = op;
        c.word_address  = wa;
        c.byte_count    = bc;
        c.write_data    = $urandom_range(255);
        c.ms_tick       = $urandom_range(3) != 0;
        if (ack_window && !noise)
            c.sda_in = (step_now == nack_at) || ($urandom_range(199) == 0);
        else
            c.sda_in = $urandom_range(1);
        return c;
    endfunction

    // present one request and hold it until the DUT takes it
    task automatic send(cmd_t c);
        if (gaps_on && $urandom_range(7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= c;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        @(negedge clk);
    endtask

    // Start a transaction, then keep ticking until the sequencer is back in
    // idle. Commands sprinkled in while busy must be ignored.
    task automatic run_txn(bit op, logic [7:0] wa, logic [7:0] bc, step_t nack_at,
                           bit noise, inout int ticks);
        send(make_tick(1'b1, op, wa, bc, nack_at, noise));
        ticks++;
        while (busy) begin
            send(make_tick($urandom_range(7) == 0, $urandom_range(1), $urandom_range(255),
                           $urandom_range(255), nack_at, noise));
            ticks++;
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_regs(logic [7:0] slave, logic [7:0] phase, logic [7:0] wait_ms);
        drain();
        write_reg(REG_SLAVE, slave);
        write_reg(REG_PHASE, phase);
        write_reg(REG_WAIT, wait_ms);
    endtask

    // Random traffic: mostly clean short transfers, some failing acks, a few
    // longer bursts and noise transactions, plus stray idle ticks.
    task automatic random_traffic(int n, bit hold_off);
        int    ticks;
        int    pick;
        step_t nack_at;
        logic [7:0] bc;
        ticks = 0;
        while (ticks < n) begin
            if (hold_off && ticks > n / 2) begin
                drain();
                hold_off = 0;
            end
            if ($urandom_range(9) == 0) begin
                send(make_tick(1'b0, $urandom_range(1), $urandom_range(255),
                               $urandom_range(255), S_IDLE, 1'b1));
                ticks++;
            end
            else begin
                pick = $urandom_range(19);
                nack_at = (pick == 0) ? S_AK_DEV : (pick == 1) ? S_AK_WORD
                        : (pick == 2) ? S_AK_DATA : (pick == 3) ? S_AK_RDEV : S_IDLE;
                bc = ($urandom_range(39) == 0) ? $urandom_range(12, 5) : $urandom_range(4);
                run_txn($urandom_range(1), $urandom_range(255), bc, nack_at,
                        $urandom_range(19) == 0, ticks);
            end
        end
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int t;
        t = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_SLAVE;
        cfg_data     = 8'd0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        stall_left   = 0;
        cycles       = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: device nack at the reset phase length
        run_txn(1'b0, 8'h00, 8'd1, S_AK_DEV, 1'b0, t);
        // short phases, reset device address and write wait
        drain();
        write_reg(REG_PHASE, 8'd1);
        run_txn(1'b0, 8'h00, 8'd1, S_IDLE, 1'b0, t);

        // zero phase length acts as one tick; no write wait
        set_regs(8'h00, 8'd0, 8'd0);
        run_txn(1'b0, 8'hFF, 8'd0, S_AK_DATA, 1'b0, t);   // count 0 -> 256, data nack
        run_txn(1'b1, 8'h5A, 8'd2, S_IDLE, 1'b0, t);
        run_txn(1'b0, 8'h10, 8'd2, S_AK_DEV, 1'b0, t);
        run_txn(1'b0, 8'h20, 8'd2, S_AK_WORD, 1'b0, t);
        run_txn(1'b1, 8'h40, 8'd2, S_AK_RDEV, 1'b0, t);
        run_txn(1'b1, 8'h60, 8'd1, S_IDLE, 1'b1, t);

        // odd device address, short write wait
        set_regs(8'hFF, 8'd1, 8'd5);
        run_txn(1'b0, 8'h80, 8'd1, S_IDLE, 1'b0, t);
        run_txn(1'b1, 8'h81, 8'd1, S_IDLE, 1'b0, t);
        random_traffic(150, 1'b0);

        set_regs($urandom_range(255), $urandom_range(3, 1), $urandom_range(5));
        random_traffic(150, 1'b1);

        set_regs($urandom_range(255), $urandom_range(3, 1), $urandom_range(5));
        random_traffic(100, 1'b0);

        // closing stretch at full rate on both sides
        set_regs($urandom_range(255), $urandom_range(2, 1), $urandom_range(3));
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        random_traffic(150, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
